/* src/sbc_pkg.sv */
`default_nettype none
package sbc_pkg;

    // cache geometry
    localparam int ENTRIES     = 64;
    localparam int SECTOR_BITS = 32;

    // fixed field widths at the ports
    localparam int MODE_W         = 2;
    localparam int SECTOR_FIELD_W = 32;
    localparam int SLOT_FIELD_W   = 6;

    // derived widths
    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int TAG_W  = (SECTOR_BITS < SECTOR_FIELD_W) ? SECTOR_BITS : SECTOR_FIELD_W;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request mode codes
    localparam logic [MODE_W-1:0] MODE_READ      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH_ONE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FLUSH_ALL = 2'd3;

    typedef logic [ENTRIES-1:0] t_vec;
    typedef logic [SLOT_W-1:0]  t_idx;
    typedef logic [TAG_W-1:0]   t_tag;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_FLUSH_ONE,
        OP_FLUSH_ALL
    } t_op;

    // classified request handed from front to back
    typedef struct packed {
        t_op  op;
        t_tag tag;
    } t_req;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CMP,
        BK_DEC,
        BK_WALK
    } t_back_state;

    typedef struct packed {
        logic found;
        t_idx idx;
    } t_find;

    // result waiting for the tag read before it goes out
    typedef struct packed {
        logic valid;
        t_idx slot;
        logic hit;
        logic fill;
        logic wb;
        logic last;
    } t_pend;

    // lowest set bit
    function automatic t_find first_set(input t_vec vec);
        t_find res;
        res = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (vec[i]) begin
                res.found = 1'b1;
                res.idx   = t_idx'(i);
            end
        end
        return res;
    endfunction

    // round-robin successor of a slot
    function automatic t_idx next_slot(input t_idx idx);
        t_idx res;
        if (idx == t_idx'(ENTRIES - 1)) begin
            res = '0;
        end else begin
            res = idx + t_idx'(1);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* src/sector_buffer_cache_tags_unit.sv */
`default_nettype none
// tag and policy controller of a fully associative write-back sector cache
// - request side: a request (i_mode, i_sector) is taken at a clock edge with
//   start high and busy low; a two-entry request queue sits between the
//   front and the back, so busy rises only when the queue is full
// - result side: o_valid strobes for one cycle per result with o_slot, o_hit,
//   o_fill_needed, the writeback fields and o_last; the receiver cannot stall
// - read, write and flush one give exactly one result; flush all gives one
//   result per dirty slot in victim-pointer order, none when nothing is dirty
// - a first result, when the back end is free, passes pop, tag compare,
//   decide and the output register in that order
// - read, write and flush one step the back end through idle, compare and
//   decide; flush all adds a walk over up to ENTRIES slots, one slot per
//   cycle through the tag ram read port
// - a tag compare against every slot runs in parallel, then the lowest hit
//   or free slot is picked in the next cycle
// - reset (synchronous, active low) clears the queue, valid and dirty bits and
//   the victim pointer; tags are not cleared and are read only for valid slots
module sector_buffer_cache_tags_unit import sbc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic [SECTOR_FIELD_W-1:0] i_sector,
    output logic                      o_valid,
    output logic [SLOT_FIELD_W-1:0]   o_slot,
    output logic                      o_hit,
    output logic                      o_fill_needed,
    output logic                      o_writeback_valid,
    output logic [SLOT_FIELD_W-1:0]   o_writeback_slot,
    output logic [SECTOR_FIELD_W-1:0] o_writeback_sector,
    output logic                      o_last
);

    // request queue hand-off
    logic req_valid;
    t_req req;
    logic req_pop;

    // front: takes and classifies requests into the queue
    sbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_sector    (i_sector),
        .i_pop       (req_pop),
        .o_req_valid (req_valid),
        .o_req       (req)
    );

    // back: tag match, allocation, eviction and flush walk
    sbc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (req_valid),
        .i_req              (req),
        .o_pop              (req_pop),
        .o_valid            (o_valid),
        .o_slot             (o_slot),
        .o_hit              (o_hit),
        .o_fill_needed      (o_fill_needed),
        .o_writeback_valid  (o_writeback_valid),
        .o_writeback_slot   (o_writeback_slot),
        .o_writeback_sector (o_writeback_sector),
        .o_last             (o_last)
    );

endmodule
`default_nettype wire

/* src/sbc_tag_ram.sv */
`default_nettype none
module sbc_tag_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* src/sbc_front.sv */
`default_nettype none
module sbc_front import sbc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic [SECTOR_FIELD_W-1:0] i_sector,
    input  logic                      i_pop,
    output logic                      o_req_valid,
    output t_req                      o_req
);

    t_req              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              push;
    logic              pop;
    t_req              item;

    function automatic logic [QPTR_W-1:0] qnext(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] res;
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + QPTR_W'(1);
        end
        return res;
    endfunction

    // classify the request
    always_comb begin
        case (i_mode)
            MODE_READ:      item.op = OP_READ;
            MODE_WRITE:     item.op = OP_WRITE;
            MODE_FLUSH_ONE: item.op = OP_FLUSH_ONE;
            MODE_FLUSH_ALL: item.op = OP_FLUSH_ALL;
            default:        item.op = OP_FLUSH_ALL;
        endcase
        item.tag = t_tag'(i_sector);
    end

    assign busy        = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign push        = start && !busy;
    assign o_req_valid = (r_cnt != '0);
    assign pop         = i_pop && o_req_valid;
    assign o_req       = r_q[r_rd];

    always_comb begin
        n_wr  = push ? qnext(r_wr) : r_wr;
        n_rd  = pop ? qnext(r_rd) : r_rd;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= item;
        end
    end

endmodule
`default_nettype wire

/* src/sbc_back.sv */
`default_nettype none
module sbc_back import sbc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    input  t_req                      i_req,
    output logic                      o_pop,
    output logic                      o_valid,
    output logic [SLOT_FIELD_W-1:0]   o_slot,
    output logic                      o_hit,
    output logic                      o_fill_needed,
    output logic                      o_writeback_valid,
    output logic [SLOT_FIELD_W-1:0]   o_writeback_slot,
    output logic [SECTOR_FIELD_W-1:0] o_writeback_sector,
    output logic                      o_last
);

    t_back_state r_state, n_state;
    t_req        r_req, n_req;
    t_tag        r_tags [ENTRIES];
    t_vec        r_valid, n_valid;
    t_vec        r_dirty, n_dirty;
    t_vec        r_match, n_match;
    t_idx        r_ptr, n_ptr;
    t_idx        r_walk, n_walk;
    t_pend       r_pend, n_pend;

    logic        tag_we;
    t_idx        tag_waddr;
    t_idx        ram_raddr;
    t_tag        ram_rdata;
    t_idx        sel;
    t_find       hit_f;
    t_find       free_f;
    t_vec        walk_oh;

    logic                      r_out_valid;
    logic [SLOT_FIELD_W-1:0]   r_out_slot;
    logic                      r_out_hit;
    logic                      r_out_fill;
    logic                      r_out_wb;
    logic [SLOT_FIELD_W-1:0]   r_out_wb_slot;
    logic [SECTOR_FIELD_W-1:0] r_out_wb_sector;
    logic                      r_out_last;

    // copy of the tags for reads at a chosen slot
    sbc_tag_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (TAG_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (r_req.tag),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign hit_f   = first_set(r_match);
    assign free_f  = first_set(~r_valid);
    assign walk_oh = t_vec'(1) << r_walk;

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_valid   = r_valid;
        n_dirty   = r_dirty;
        n_match   = r_match;
        n_ptr     = r_ptr;
        n_walk    = r_walk;
        n_pend    = '0;
        o_pop     = 1'b0;
        tag_we    = 1'b0;
        sel       = r_ptr;
        ram_raddr = r_ptr;
        case (r_state)
            BK_IDLE: begin
                if (i_req_valid) begin
                    o_pop   = 1'b1;
                    n_req   = i_req;
                    n_state = BK_CMP;
                end
            end
            BK_CMP: begin
                // parallel tag compare, one comparator per slot
                for (int i = 0; i < ENTRIES; i++) begin
                    n_match[i] = r_valid[i] && (r_tags[i] == r_req.tag);
                end
                n_state = BK_DEC;
            end
            BK_DEC: begin
                n_state = BK_IDLE;
                case (r_req.op)
                    OP_READ, OP_WRITE: begin
                        n_pend.valid = 1'b1;
                        n_pend.last  = 1'b1;
                        if (hit_f.found) begin
                            sel        = hit_f.idx;
                            n_pend.hit = 1'b1;
                        end else begin
                            n_pend.fill = (r_req.op == OP_READ);
                            tag_we      = 1'b1;
                            if (free_f.found) begin
                                sel          = free_f.idx;
                                n_valid[sel] = 1'b1;
                            end else begin
                                // evict the round-robin victim
                                sel          = r_ptr;
                                n_pend.wb    = r_dirty[r_ptr];
                                n_dirty[sel] = 1'b0;
                                n_ptr        = next_slot(r_ptr);
                            end
                        end
                        if (r_req.op == OP_WRITE) begin
                            n_dirty[sel] = 1'b1;
                        end
                        n_pend.slot = sel;
                        ram_raddr   = sel;
                    end
                    OP_FLUSH_ONE: begin
                        n_pend.valid = 1'b1;
                        n_pend.last  = 1'b1;
                        if (hit_f.found) begin
                            sel          = hit_f.idx;
                            n_pend.slot  = sel;
                            n_pend.hit   = 1'b1;
                            n_pend.wb    = r_dirty[sel];
                            n_dirty[sel] = 1'b0;
                            n_ptr        = next_slot(sel);
                            ram_raddr    = sel;
                        end
                    end
                    OP_FLUSH_ALL: begin
                        if (r_dirty != '0) begin
                            n_walk  = r_ptr;
                            n_state = BK_WALK;
                        end
                    end
                    default: ;
                endcase
            end
            BK_WALK: begin
                // one slot per cycle from the victim pointer round
                ram_raddr = r_walk;
                n_walk    = next_slot(r_walk);
                if (r_dirty[r_walk]) begin
                    n_pend.valid    = 1'b1;
                    n_pend.slot     = r_walk;
                    n_pend.wb       = 1'b1;
                    n_pend.last     = ((r_dirty & ~walk_oh) == '0);
                    n_dirty[r_walk] = 1'b0;
                    if (n_pend.last) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign tag_waddr = sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_ptr       <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_dirty     <= n_dirty;
            r_ptr       <= n_ptr;
            r_pend      <= n_pend;
            r_out_valid <= r_pend.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_match <= n_match;
        r_walk  <= n_walk;
        if (tag_we) begin
            r_tags[tag_waddr] <= r_req.tag;
        end
        r_out_slot      <= SLOT_FIELD_W'(r_pend.slot);
        r_out_hit       <= r_pend.hit;
        r_out_fill      <= r_pend.fill;
        r_out_wb        <= r_pend.wb;
        r_out_wb_slot   <= r_pend.wb ? SLOT_FIELD_W'(r_pend.slot) : '0;
        r_out_wb_sector <= r_pend.wb ? SECTOR_FIELD_W'(ram_rdata) : '0;
        r_out_last      <= r_pend.last;
    end

    assign o_valid            = r_out_valid;
    assign o_slot             = r_out_slot;
    assign o_hit              = r_out_hit;
    assign o_fill_needed      = r_out_fill;
    assign o_writeback_valid  = r_out_wb;
    assign o_writeback_slot   = r_out_wb_slot;
    assign o_writeback_sector = r_out_wb_sector;
    assign o_last             = r_out_last;

endmodule
`default_nettype wire

/* src/sbc_checker.sv */
`default_nettype none
module sbc_checker import sbc_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [MODE_W-1:0]         i_mode,
    input logic [SECTOR_FIELD_W-1:0] i_sector,
    input logic                      o_valid,
    input logic [SLOT_FIELD_W-1:0]   o_slot,
    input logic                      o_hit,
    input logic                      o_fill_needed,
    input logic                      o_writeback_valid,
    input logic [SLOT_FIELD_W-1:0]   o_writeback_slot,
    input logic [SECTOR_FIELD_W-1:0] o_writeback_sector,
    input logic                      o_last
);

    // no strobe right after reset
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // a writeback names the slot of its own result
    a_wb_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_writeback_valid |-> (o_valid && o_writeback_slot == o_slot))
        else $error("writeback slot differs from result slot");

    // writeback fields read zero when nothing is written back
    a_wb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_writeback_valid) |->
            (o_writeback_slot == '0 && o_writeback_sector == '0))
        else $error("stale writeback fields");

    // a fill belongs to a read miss, a single-result request
    a_fill_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fill_needed) |-> (!o_hit && o_last))
        else $error("fill on a hit or on a multi-result request");

    // a hit always closes its request
    a_hit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> o_last)
        else $error("hit result not marked last");

endmodule

bind sector_buffer_cache_tags_unit sbc_checker u_sbc_checker (.*);
`default_nettype wire
